[rtl/core/olist_pkg.sv]
// Package for the ordered tag list: request/result types, codes and sequencer states.
`timescale 1ns / 1ps
package olist_pkg;

	localparam int TAG_FIELD_W = 8;
	localparam int POS_FIELD_W = 6;
	localparam int LEN_FIELD_W = 5;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_MOVE   = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADPOS = 3'd3,
		ST_SAME   = 3'd4,
		ST_SINGLE = 3'd5
	} status_t;

	typedef struct packed {
		req_kind_t                req_type;
		logic [TAG_FIELD_W-1:0]   order_tag;
		logic [POS_FIELD_W-1:0]   position;
		logic [POS_FIELD_W-1:0]   new_position;
	} olist_req_t;

	typedef struct packed {
		status_t                  status;
		logic [LEN_FIELD_W-1:0]   list_length;
		logic [TAG_FIELD_W-1:0]   read_tag;
	} olist_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_HOLD_RD,
		S_HOLD_WT,
		S_SH_RD,
		S_SH_WR,
		S_FIN_WR,
		S_TAG_RD,
		S_TAG_WT,
		S_RESP
	} seq_state_t;

endpackage

[rtl/core/ordered_list_append_move_remove_top.sv]
// Top level of the ordered tag list: entry memory, shift sequencer and result port.
`timescale 1ns / 1ps
// Ordered tag list of up to DEPTH entries with append, remove, move and
// read-at-position requests (positions are 1-based). A transaction is taken
// on a clock edge with start high and busy low; busy then stays high until
// the result has been shown. The result sits on the result port for exactly
// one cycle, flagged by done, and the receiver cannot stall it: it must take
// it in that cycle. Every request gives one result: status, the list length
// after the request, and the tag read (zero except for a good read).
// After the done cycle the block returns to idle with busy low, and only
// there can the next transaction be taken.
// The cost is set by the entry memory, with one write port and a registered
// read port: closing or opening a gap moves one entry at a time (read, then
// write) through one index incrementer/decrementer and compare.
// Entries hold no reset value; only entries below the pre-request count are used.
module ordered_list_append_move_remove_top #(
	parameter int DEPTH     = 16,
	parameter int TAG_WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  olist_pkg::olist_req_t request,
	output logic                done,
	output olist_pkg::olist_rsp_t result
);
	import olist_pkg::*;

	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry index
	localparam int CW   = $clog2(DEPTH + 1);                  // entry count
	localparam int CMPW = (CW > POS_FIELD_W) ? CW : POS_FIELD_W;

	// Entry memory: one write and one registered read per cycle.
	logic [TAG_WIDTH-1:0] mem [DEPTH];
	logic [TAG_WIDTH-1:0] rdata_q;
	logic                 we;
	logic [IW-1:0]        waddr;
	logic [IW-1:0]        raddr;
	logic [TAG_WIDTH-1:0] wdata;

	// Sequencer and datapath registers.
	seq_state_t           state_q, state_d;
	olist_req_t           req_q;
	logic [CW-1:0]        count_q, count_d;
	logic [IW-1:0]        cur_q, cur_d;      // entry being rewritten
	logic [IW-1:0]        last_q, last_d;    // where the walk stops
	logic                 up_q, up_d;        // walk toward the tail
	logic [TAG_WIDTH-1:0] held_q, held_d;    // entry lifted out by a move
	status_t              status_q, status_d;
	logic [TAG_WIDTH-1:0] rtag_q, rtag_d;

	// Request decode helpers.
	logic [CMPW-1:0]        cnt_ext, pos_ext, npos_ext;
	logic                   pos_ok, npos_ok;
	logic [POS_FIELD_W-1:0] pm1, npm1;
	logic [IW-1:0]          pidx, nidx, cur_nxt;
	logic [TAG_WIDTH-1:0]   tag_in;

	assign cnt_ext  = CMPW'(count_q);
	assign pos_ext  = CMPW'(req_q.position);
	assign npos_ext = CMPW'(req_q.new_position);
	assign pos_ok   = (req_q.position != '0) && (pos_ext <= cnt_ext);
	assign npos_ok  = (req_q.new_position != '0) && (npos_ext <= cnt_ext);
	assign pm1      = req_q.position - POS_FIELD_W'(1);
	assign npm1     = req_q.new_position - POS_FIELD_W'(1);
	assign pidx     = pm1[IW-1:0];
	assign nidx     = npm1[IW-1:0];
	assign cur_nxt  = up_q ? (cur_q + IW'(1)) : (cur_q - IW'(1));
	assign tag_in   = TAG_WIDTH'(req_q.order_tag);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);
	assign result.status      = status_q;
	assign result.list_length = LEN_FIELD_W'(count_q);
	// Result tag on the port is the low field bits of the stored tag.
	assign result.read_tag    = TAG_FIELD_W'(rtag_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_OK;
			rtag_q   <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			status_q <= status_d;
			rtag_q   <= rtag_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		cur_q  <= cur_d;
		last_q <= last_d;
		up_q   <= up_d;
		held_q <= held_d;
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cur_d    = cur_q;
		last_d   = last_q;
		up_d     = up_q;
		held_d   = held_q;
		status_d = status_q;
		rtag_d   = rtag_q;
		we       = 1'b0;
		waddr    = cur_q;
		wdata    = rdata_q;
		raddr    = cur_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				rtag_d   = '0;
				status_d = ST_OK;
				state_d  = S_RESP;
				case (req_q.req_type)
					REQ_APPEND: begin
						if (count_q == CW'(DEPTH)) begin
							status_d = ST_FULL;
						end else begin
							we      = 1'b1;
							waddr   = count_q[IW-1:0];
							wdata   = tag_in;
							count_d = count_q + CW'(1);
						end
					end
					REQ_REMOVE: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else if (!pos_ok) begin
							status_d = ST_BADPOS;
						end else begin
							cur_d   = pidx;
							last_d  = IW'(count_q - CW'(1));
							up_d    = 1'b1;
							count_d = count_q - CW'(1);
							if (pidx != IW'(count_q - CW'(1))) begin
								state_d = S_SH_RD;
							end
						end
					end
					REQ_MOVE: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else if (count_q == CW'(1)) begin
							status_d = ST_SINGLE;
						end else if (!pos_ok || !npos_ok) begin
							status_d = ST_BADPOS;
						end else if (req_q.position == req_q.new_position) begin
							status_d = ST_SAME;
						end else begin
							cur_d   = pidx;
							last_d  = nidx;
							up_d    = (req_q.new_position > req_q.position);
							state_d = S_HOLD_RD;
						end
					end
					REQ_READ: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else if (!pos_ok) begin
							status_d = ST_BADPOS;
						end else begin
							state_d = S_TAG_RD;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			S_HOLD_RD: begin
				raddr   = cur_q;
				state_d = S_HOLD_WT;
			end
			S_HOLD_WT: begin
				held_d  = rdata_q;
				state_d = S_SH_RD;
			end
			S_SH_RD: begin
				raddr   = cur_nxt;
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				// neighbor slides into the current slot
				we    = 1'b1;
				waddr = cur_q;
				wdata = rdata_q;
				cur_d = cur_nxt;
				if (cur_nxt != last_q) begin
					state_d = S_SH_RD;
				end else if (req_q.req_type == REQ_MOVE) begin
					state_d = S_FIN_WR;
				end else begin
					state_d = S_RESP;
				end
			end
			S_FIN_WR: begin
				we      = 1'b1;
				waddr   = cur_q;
				wdata   = held_q;
				state_d = S_RESP;
			end
			S_TAG_RD: begin
				raddr   = pidx;
				state_d = S_TAG_WT;
			end
			S_TAG_WT: begin
				rtag_d  = rdata_q;
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
